### design/rfd_pkg.sv
// Shared types and codes for the request frame deframer.
`default_nettype none

package rfd_pkg;

    localparam int unsigned CFG_ADDR_W = 5;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MAGIC     = 3'd0;
    localparam logic [2:0] REG_PROFILE_A = 3'd1;
    localparam logic [2:0] REG_PROFILE_B = 3'd2;
    localparam logic [2:0] REG_LIMIT_URL = 3'd3;
    localparam logic [2:0] REG_LIMIT_MTH = 3'd4;
    localparam logic [2:0] REG_LIMIT_HDR = 3'd5;
    localparam logic [2:0] REG_LIMIT_BDY = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_PROFILE   = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_TRAILING  = 3'd5;

    localparam logic [1:0] FIELD_BODY = 2'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_req_in;

    typedef struct packed {
        logic       payload_valid;
        logic [1:0] field_id;
        logic [7:0] payload_byte;
        logic       field_end;
        logic       frame_end;
        logic       frame_ok;
        logic [2:0] error_code;
        logic [7:0] profile_seen;
    } t_req_out;

endpackage

`default_nettype wire

### design/request_frame_deframer_unit.sv
// A request's result is captured in the output register when it is accepted.
// Throughput: one byte per cycle; the per-byte work is one word compare or one
// length compare and a counter step, done between the input handshake and the
// result register. Input is stalled only while a held result is stalled.
// Reset (synchronous, active low) restores the configuration defaults and
// returns the frame parser to the start of a frame.
`default_nettype none

module request_frame_deframer_unit #(
    parameter int unsigned LEN_WIDTH = 32
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  rfd_pkg::t_req_in               i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output rfd_pkg::t_req_out                    o_out_data,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [rfd_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire  [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import rfd_pkg::*;

    localparam logic [2:0] PH_MAGIC   = 3'd0;
    localparam logic [2:0] PH_PROFILE = 3'd1;
    localparam logic [2:0] PH_LENGTH  = 3'd2;
    localparam logic [2:0] PH_DATA    = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    // Configuration registers
    logic [31:0] r_magic;
    logic [7:0]  r_prof_a;
    logic [7:0]  r_prof_b;
    logic [23:0] r_limit [4];

    // Frame state
    logic [2:0]           r_phase, n_phase;
    logic [1:0]           r_biw, n_biw;
    logic [23:0]          r_accum, n_accum;
    logic [LEN_WIDTH-1:0] r_left, n_left;
    logic [1:0]           r_field, n_field;
    logic [2:0]           r_err, n_err;
    logic [7:0]           r_prof, n_prof;

    logic      r_out_valid;
    t_req_out  r_out, n_out;

    logic        in_accept;
    logic        cfg_write;
    logic [2:0]  cfg_idx;
    logic [31:0] word;
    logic [31:0] len_hi;
    logic        too_long;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            REG_MAGIC:     prdata = r_magic;
            REG_PROFILE_A: prdata = {24'd0, r_prof_a};
            REG_PROFILE_B: prdata = {24'd0, r_prof_b};
            REG_LIMIT_URL: prdata = {8'd0, r_limit[0]};
            REG_LIMIT_MTH: prdata = {8'd0, r_limit[1]};
            REG_LIMIT_HDR: prdata = {8'd0, r_limit[2]};
            REG_LIMIT_BDY: prdata = {8'd0, r_limit[3]};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic    <= 32'd0;
            r_prof_a   <= 8'd0;
            r_prof_b   <= 8'd1;
            r_limit[0] <= 24'd8192;
            r_limit[1] <= 24'd16;
            r_limit[2] <= 24'd65536;
            r_limit[3] <= 24'd16777215;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_MAGIC:     r_magic    <= pwdata;
                REG_PROFILE_A: r_prof_a   <= pwdata[7:0];
                REG_PROFILE_B: r_prof_b   <= pwdata[7:0];
                REG_LIMIT_URL: r_limit[0] <= pwdata[23:0];
                REG_LIMIT_MTH: r_limit[1] <= pwdata[23:0];
                REG_LIMIT_HDR: r_limit[2] <= pwdata[23:0];
                REG_LIMIT_BDY: r_limit[3] <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Completed little-endian word when the fourth byte arrives
    assign word     = {i_in_data.frame_byte, r_accum};
    assign len_hi   = word >> LEN_WIDTH;
    assign too_long = (word > {8'd0, r_limit[r_field]}) || (len_hi != 32'd0);

    always_comb begin
        n_phase = r_phase;
        n_biw   = r_biw;
        n_accum = r_accum;
        n_left  = r_left;
        n_field = r_field;
        n_err   = r_err;
        n_prof  = r_prof;

        n_out               = '0;
        n_out.frame_end     = i_in_data.frame_last;

        case (r_phase)
            PH_MAGIC, PH_LENGTH: begin
                if (r_biw == 2'd3) begin
                    n_biw = 2'd0;
                    if (r_phase == PH_MAGIC) begin
                        if (word != r_magic) begin
                            n_err   = ERR_MAGIC;
                            n_phase = PH_ERROR;
                        end else begin
                            n_phase = PH_PROFILE;
                        end
                    end else if (too_long) begin
                        n_err   = ERR_TOO_LONG;
                        n_phase = PH_ERROR;
                    end else if (word == 32'd0) begin
                        // empty field: advance straight to the next length, or finish after the body
                        if (r_field == FIELD_BODY) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_field = r_field + 2'd1;
                        end
                    end else begin
                        n_left  = word[LEN_WIDTH-1:0];
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_biw = r_biw + 2'd1;
                    case (r_biw)
                        2'd0:    n_accum[7:0]   = i_in_data.frame_byte;
                        2'd1:    n_accum[15:8]  = i_in_data.frame_byte;
                        default: n_accum[23:16] = i_in_data.frame_byte;
                    endcase
                end
            end
            PH_PROFILE: begin
                n_prof = i_in_data.frame_byte;
                if (i_in_data.frame_byte == r_prof_a || i_in_data.frame_byte == r_prof_b) begin
                    n_phase = PH_LENGTH;
                    n_field = 2'd0;
                    n_biw   = 2'd0;
                end else begin
                    n_err   = ERR_PROFILE;
                    n_phase = PH_ERROR;
                end
            end
            PH_DATA: begin
                n_out.payload_valid = 1'b1;
                n_out.field_id      = r_field;
                n_out.payload_byte  = i_in_data.frame_byte;
                n_left              = r_left - {{(LEN_WIDTH-1){1'b0}}, 1'b1};
                if (r_left == {{(LEN_WIDTH-1){1'b0}}, 1'b1}) begin
                    n_out.field_end = 1'b1;
                    n_biw           = 2'd0;
                    if (r_field == FIELD_BODY) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_field = r_field + 2'd1;
                        n_phase = PH_LENGTH;
                    end
                end
            end
            PH_DONE: begin
                n_err   = ERR_TRAILING;
                n_phase = PH_ERROR;
            end
            default: ;
        endcase

        if (i_in_data.frame_last) begin
            if (n_err == ERR_NONE && n_phase != PH_DONE) begin
                n_err = ERR_TRUNCATED;
            end
            n_out.frame_ok = (n_err == ERR_NONE);
        end
        n_out.error_code   = n_err;
        n_out.profile_seen = n_prof;

        // frame boundary: drop all frame state
        if (i_in_data.frame_last) begin
            n_phase = PH_MAGIC;
            n_biw   = 2'd0;
            n_accum = 24'd0;
            n_left  = '0;
            n_field = 2'd0;
            n_err   = ERR_NONE;
            n_prof  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_biw       <= 2'd0;
            r_accum     <= 24'd0;
            r_left      <= '0;
            r_field     <= 2'd0;
            r_err       <= ERR_NONE;
            r_prof      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase <= n_phase;
                r_biw   <= n_biw;
                r_accum <= n_accum;
                r_left  <= n_left;
                r_field <= n_field;
                r_err   <= n_err;
                r_prof  <= n_prof;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_ok_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_ok) |->
        (o_out_data.frame_end && o_out_data.error_code == ERR_NONE))
        else $error("frame_ok reported with an error or off frame end");

    a_field_end_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.field_end) |-> o_out_data.payload_valid)
        else $error("field_end without payload");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.frame_last) |=>
        (r_phase == PH_MAGIC && r_err == ERR_NONE && r_biw == 2'd0))
        else $error("frame state not cleared after last byte");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in_data.frame_last && r_err != ERR_NONE) |=>
        (r_err == $past(r_err)))
        else $error("latched error overwritten within a frame");
`endif

endmodule

`default_nettype wire

### test/tb.sv
// Request frame deframer testbench: directed frames, then random frames checked by a predictor.
`timescale 1ns / 1ps

module tb;
    import rfd_pkg::*;

    localparam int DIR_N     = 30;
    localparam int IDLE_MAX  = 5000;
    localparam int PHASE_REQ = 185;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_PROFILE, PH_LENGTH, PH_DATA, PH_DONE, PH_ERROR
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic       fixed;
        t_req_out   want;
    } t_dir_row;

    typedef struct packed {
        logic     fixed;
        t_req_out want;
    } t_known;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_req_in               in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_req_out              o_out_data;
    logic [31:0]           prdata;
    logic                  pready;

    // configuration as the block should hold it
    logic [31:0] cfg_magic;
    logic [7:0]  cfg_prof_a;
    logic [7:0]  cfg_prof_b;
    logic [23:0] cfg_limit [4];

    // parser state of the predictor
    t_parse_phase ps_phase;
    logic [1:0]   ps_nib;
    logic [31:0]  ps_word;
    logic [31:0]  ps_left;
    logic [1:0]   ps_field;
    logic [2:0]   ps_err;
    logic [7:0]   ps_profile;

    t_req_out   expected_q [$];
    t_known     known_q [$];
    logic [7:0] frame_bytes [$];
    t_dir_row   directed_tab [0:DIR_N-1];

    int mismatches     = 0;
    int requests_sent  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;

    request_frame_deframer_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_frame();
        ps_phase   = PH_MAGIC;
        ps_nib     = 2'd0;
        ps_word    = '0;
        ps_left    = '0;
        ps_field   = 2'd0;
        ps_err     = ERR_NONE;
        ps_profile = 8'h00;
    endfunction

    // Gather a little-endian word; true once its fourth byte is in.
    function automatic bit word_done(input logic [7:0] b);
        if (ps_nib == 2'd0)
            ps_word = {24'd0, b};
        else
            ps_word[ps_nib*8 +: 8] = b;
        if (ps_nib == 2'd3) begin
            ps_nib = 2'd0;
            return 1'b1;
        end
        ps_nib = ps_nib + 2'd1;
        return 1'b0;
    endfunction

    function automatic void latch_error(input logic [2:0] code);
        if (ps_err == ERR_NONE)
            ps_err = code;
        ps_phase = PH_ERROR;
    endfunction

    function automatic void next_field();
        ps_nib = 2'd0;
        if (ps_field == FIELD_BODY) begin
            ps_phase = PH_DONE;
        end else begin
            ps_field = ps_field + 2'd1;
            ps_phase = PH_LENGTH;
        end
    endfunction

    function automatic t_req_out deframe_byte(input t_req_in req);
        t_req_out   r;
        logic [7:0] b;
        r = '0;
        b = req.frame_byte;
        case (ps_phase)
            PH_MAGIC: begin
                if (word_done(b)) begin
                    if (ps_word != cfg_magic)
                        latch_error(ERR_MAGIC);
                    else
                        ps_phase = PH_PROFILE;
                end
            end
            PH_PROFILE: begin
                ps_profile = b;
                if (b == cfg_prof_a || b == cfg_prof_b) begin
                    ps_phase = PH_LENGTH;
                    ps_field = 2'd0;
                    ps_nib   = 2'd0;
                end else begin
                    latch_error(ERR_PROFILE);
                end
            end
            PH_LENGTH: begin
                if (word_done(b)) begin
                    if (ps_word > {8'd0, cfg_limit[ps_field]}) begin
                        latch_error(ERR_TOO_LONG);
                    end else if (ps_word == 32'd0) begin
                        next_field();
                    end else begin
                        ps_left  = ps_word;
                        ps_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                r.payload_valid = 1'b1;
                r.field_id      = ps_field;
                r.payload_byte  = b;
                ps_left         = ps_left - 32'd1;
                if (ps_left == 32'd0) begin
                    r.field_end = 1'b1;
                    next_field();
                end
            end
            PH_DONE: latch_error(ERR_TRAILING);
            default: ;
        endcase
        if (req.frame_last) begin
            r.frame_end = 1'b1;
            if (ps_err == ERR_NONE && ps_phase != PH_DONE)
                latch_error(ERR_TRUNCATED);
            r.frame_ok = (ps_err == ERR_NONE);
        end
        r.error_code   = ps_err;
        r.profile_seen = ps_profile;
        if (req.frame_last)
            clear_frame();
        return r;
    endfunction

    function automatic void report(input string what, input t_req_out want,
                                   input t_req_out got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: exp pv=%0b fid=%0d byte=%02h fe=%0b fend=%0b ok=%0b err=%0d prof=%02h",
                     what, want.payload_valid, want.field_id, want.payload_byte,
                     want.field_end, want.frame_end, want.frame_ok, want.error_code,
                     want.profile_seen);
        if (mismatches <= 10)
            $display("    got pv=%0b fid=%0d byte=%02h fe=%0b fend=%0b ok=%0b err=%0d prof=%02h",
                     got.payload_valid, got.field_id, got.payload_byte, got.field_end,
                     got.frame_end, got.frame_ok, got.error_code, got.profile_seen);
    endfunction

    always @(posedge clk) begin : scoreboard
        t_req_out want;
        t_known   k;
        if (rst_n) begin
            // retire before predicting: a result this edge is from an older request
            if (o_out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", '0, o_out_data);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_data.payload_valid !== want.payload_valid ||
                        o_out_data.field_id      !== want.field_id      ||
                        o_out_data.payload_byte  !== want.payload_byte  ||
                        o_out_data.field_end     !== want.field_end     ||
                        o_out_data.frame_end     !== want.frame_end     ||
                        o_out_data.frame_ok      !== want.frame_ok      ||
                        o_out_data.error_code    !== want.error_code    ||
                        o_out_data.profile_seen  !== want.profile_seen)
                        report("mismatch", want, o_out_data);
                end
            end
            if (in_valid && !o_in_stall) begin
                k    = known_q.pop_front();
                want = deframe_byte(in_data);
                expected_q.push_back(k.fixed ? k.want : want);
            end
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_req(input t_req_in req, input logic fixed, input t_req_out want);
        t_known k;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        k.fixed = fixed;
        k.want  = want;
        known_q.push_back(k);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(w[i*8 +: 8]);
    endfunction

    task automatic send_random_frame();
        int          kind;
        int          n;
        int          cut;
        int          bad_field;
        logic [31:0] len;
        logic [23:0] lim;
        logic [7:0]  prof;
        t_req_in     req;
        frame_bytes.delete();
        kind      = $urandom_range(99);
        bad_field = $urandom_range(3);
        if (kind < 8) begin
            // plain noise
            n = $urandom_range(1, 8);
            repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
        end else begin
            put_word(kind < 14 ? cfg_magic ^ (32'd1 << $urandom_range(31)) : cfg_magic);
            if (kind >= 14 && kind < 20) begin
                do prof = 8'($urandom_range(255));
                while (prof == cfg_prof_a || prof == cfg_prof_b);
            end else begin
                prof = $urandom_range(1) ? cfg_prof_a : cfg_prof_b;
            end
            frame_bytes.push_back(prof);
            for (int f = 0; f < 4; f++) begin
                lim = cfg_limit[f];
                if (kind >= 20 && kind < 28 && f == bad_field) begin
                    len = $urandom_range(1) ? {8'd0, lim} + 32'd1
                                            : ($urandom() | 32'h0100_0000);
                    put_word(len);
                    n = $urandom_range(3);
                    repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
                    break;
                end
                len = $urandom_range(lim < 24'd5 ? lim : 24'd5);
                if (lim <= 24'd40 && $urandom_range(7) == 0)
                    len = {8'd0, lim};
                put_word(len);
                repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
            end
            if (kind >= 28 && kind < 40) begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                repeat (cut) void'(frame_bytes.pop_back());
            end else if (kind >= 40 && kind < 50) begin
                n = $urandom_range(1, 3);
                repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
            end
        end
        foreach (frame_bytes[i]) begin
            req.frame_byte = frame_bytes[i];
            req.frame_last = (i == frame_bytes.size() - 1);
            send_req(req, 1'b0, '0);
        end
    endtask

    task automatic run_frames(input int target);
        int start;
        start = requests_sent;
        while (requests_sent - start < target)
            send_random_frame();
    endtask

    // Drop valid and hold until every expected result is back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk);
        while (expected_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk);
        while (!pready);
        case (idx)
            REG_MAGIC:     cfg_magic  = val;
            REG_PROFILE_A: cfg_prof_a = val[7:0];
            REG_PROFILE_B: cfg_prof_b = val[7:0];
            REG_LIMIT_URL, REG_LIMIT_MTH, REG_LIMIT_HDR, REG_LIMIT_BDY:
                cfg_limit[2'(idx - REG_LIMIT_URL)] = val[23:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [31:0] magic, input logic [7:0] pa,
                               input logic [7:0] pb, input logic [23:0] l_url,
                               input logic [23:0] l_mth, input logic [23:0] l_hdr,
                               input logic [23:0] l_bdy);
        reg_write(REG_MAGIC, magic);
        reg_write(REG_PROFILE_A, {24'd0, pa});
        reg_write(REG_PROFILE_B, {24'd0, pb});
        reg_write(REG_LIMIT_URL, {8'd0, l_url});
        reg_write(REG_LIMIT_MTH, {8'd0, l_mth});
        reg_write(REG_LIMIT_HDR, {8'd0, l_hdr});
        reg_write(REG_LIMIT_BDY, {8'd0, l_bdy});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : main
        t_req_in req;
        logic [7:0] shared_prof;
        cfg_magic    = 32'd0;
        cfg_prof_a   = 8'd0;
        cfg_prof_b   = 8'd1;
        cfg_limit[0] = 24'd8192;
        cfg_limit[1] = 24'd16;
        cfg_limit[2] = 24'd65536;
        cfg_limit[3] = 24'hFF_FFFF;
        clear_frame();
        // byte, last, fixed expectation, then pv fid byte fe fend ok err prof
        directed_tab = '{
            // lone byte ends the frame inside the magic word
            '{8'hFF, 1'b1, 1'b1, '{1'b0, 2'd0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_TRUNCATED, 8'h00}},
            // good magic, unknown profile, then one byte swallowed after the error
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, '{1'b0, 2'd0, 8'h00, 1'b0, 1'b0, 1'b0, ERR_PROFILE, 8'hFF}},
            '{8'hAA, 1'b1, 1'b1, '{1'b0, 2'd0, 8'h00, 1'b0, 1'b1, 1'b0, ERR_PROFILE, 8'hFF}},
            // good frame: one url byte, empty method and headers, one body byte
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, '{1'b1, 2'd0, 8'hFF, 1'b1, 1'b0, 1'b0, ERR_NONE, 8'h01}},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, '{1'b1, FIELD_BODY, 8'h00, 1'b1, 1'b1, 1'b1, ERR_NONE, 8'h01}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration, no idling
        foreach (directed_tab[i]) begin
            req.frame_byte = directed_tab[i].frame_byte;
            req.frame_last = directed_tab[i].frame_last;
            send_req(req, directed_tab[i].fixed, directed_tab[i].want);
        end
        run_frames(PHASE_REQ);
        drain();

        // empty url only, widest method limit; sender idles
        load_config($urandom(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    24'd0, 24'hFF_FFFF, 24'd3, 24'd5);
        send_idle_pct  = 58;
        recv_stall_pct = 0;
        run_frames(PHASE_REQ);
        drain();

        // all-ones magic, extreme profile codes, widest limits; receiver stalls
        load_config(32'hFFFF_FFFF, 8'hFF, 8'h00,
                    24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 58;
        run_frames(PHASE_REQ);
        drain();

        // one profile code only, tight limits; both sides idle
        shared_prof = 8'($urandom_range(255));
        load_config($urandom(), shared_prof, shared_prof,
                    24'($urandom_range(8)), 24'($urandom_range(8)), 24'($urandom_range(8)),
                    24'($urandom_range(8)));
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_frames(PHASE_REQ);
        drain();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
design/rfd_pkg.sv
design/request_frame_deframer_unit.sv
test/tb.sv
